### hw/rtl/ifp_pkg.sv
// ifp_pkg: types, character codes and helper functions for the
// infix-to-prefix operator stack core. No dependencies.
`timescale 1ns / 1ps

package ifp_pkg;

  localparam int DEF_STACK_DEPTH = 32;
  localparam int CHAR_W = 8;
  localparam int CODE_W = 3;
  localparam int STAT_W = 2;

  // stack entry codes
  localparam logic [CODE_W-1:0] CODE_PLUS       = 3'd0;
  localparam logic [CODE_W-1:0] CODE_MINUS      = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MUL        = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DIV        = 3'd3;
  localparam logic [CODE_W-1:0] CODE_CLOSE_BRACE = 3'd4;
  localparam logic [CODE_W-1:0] CODE_CLOSE_PAREN = 3'd5;
  localparam logic [CODE_W-1:0] CODE_CLOSE_BRACK = 3'd6;
  localparam logic [CODE_W-1:0] CODE_CLOSE_BASE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNMATCHED = 2'd2;

  localparam logic [1:0] PREC_BRACKET = 2'd1;
  localparam logic [1:0] PREC_ADD     = 2'd2;
  localparam logic [1:0] PREC_MUL     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_PUSH,
    ST_AFTER,
    ST_DONE
  } ifp_state_t;

  typedef enum logic [1:0] {
    MODE_OPEN,
    MODE_OP,
    MODE_FLUSH
  } ifp_mode_t;

  function automatic logic is_close_char(input logic [CHAR_W-1:0] ch);
    return (ch == 8'h7D) || (ch == 8'h29) || (ch == 8'h5D);
  endfunction

  function automatic logic is_open_char(input logic [CHAR_W-1:0] ch);
    return (ch == 8'h7B) || (ch == 8'h28) || (ch == 8'h5B);
  endfunction

  function automatic logic is_op_char(input logic [CHAR_W-1:0] ch);
    return (ch == 8'h2B) || (ch == 8'h2D) || (ch == 8'h2A) || (ch == 8'h2F);
  endfunction

  // code of an operator or closing bracket character
  function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] c;
    case (ch)
      8'h2B:   c = CODE_PLUS;
      8'h2D:   c = CODE_MINUS;
      8'h2A:   c = CODE_MUL;
      8'h2F:   c = CODE_DIV;
      8'h7D:   c = CODE_CLOSE_BRACE;
      8'h29:   c = CODE_CLOSE_PAREN;
      default: c = CODE_CLOSE_BRACK;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      CODE_PLUS:        ch = 8'h2B;
      CODE_MINUS:       ch = 8'h2D;
      CODE_MUL:         ch = 8'h2A;
      CODE_DIV:         ch = 8'h2F;
      CODE_CLOSE_BRACE: ch = 8'h7D;
      CODE_CLOSE_PAREN: ch = 8'h29;
      default:          ch = 8'h5D;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] code);
    logic [1:0] p;
    if (code < CODE_MUL) begin
      p = PREC_ADD;
    end else if (code < CODE_CLOSE_BASE) begin
      p = PREC_MUL;
    end else begin
      p = PREC_BRACKET;
    end
    return p;
  endfunction

endpackage

### hw/rtl/ifp_ram.sv
// ifp_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
`timescale 1ns / 1ps

module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/infix_to_prefix_operator_stack_core.sv
// infix_to_prefix_operator_stack_core: operator stack for infix-to-prefix
// conversion, stack held in one ifp_ram instance.
// Depends on ifp_pkg and ifp_ram.
`timescale 1ns / 1ps

// Usage
// - s_axis carries one expression character per transaction, rightmost first;
//   tlast marks the leftmost character, which also flushes the stack.
// - m_axis carries the reversed prefix expression one character per
//   transaction. tlast closes the characters caused by one input transaction,
//   tuser[0] marks the last character of the expression and tuser[2:1] holds
//   the status (0 ok, 1 stack overflow, 2 unmatched bracket), equal on all
//   characters of one input transaction.
// - an input is taken only when the sequencer is idle. A plain character or a
//   closing bracket passes through ST_AFTER and ST_DONE. An opening bracket, an
//   operator or the flush walks the stack: a registered stack RAM read and a
//   compare for every entry popped and for the compare that stops the walk, or
//   the read alone when the walk ends on an empty stack; an operator adds a push.
//   Each character is held back one step so the item's last one carries tlast.
// - results leave through an output register, so the next input can be taken
//   while a result waits. A stalled receiver holds the sequencer only when a
//   new character must replace one still waiting in the output register.
// - rst empties the stack and drops any pending result; the stack RAM itself
//   is never cleared, only entries below the fill count are read.

module infix_to_prefix_operator_stack_core
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,  // in_char [7:0]
  input  logic              s_axis_tlast,  // is_final
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,  // out_char [7:0]
  output logic              m_axis_tlast,  // run_last
  output logic [2:0]        m_axis_tuser   // expr_done [0], status [2:1]
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  ifp_state_t state, state_next;
  ifp_mode_t  mode, mode_next;

  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     close_cnt, close_cnt_next;
  logic [CODE_W-1:0] op_code;
  logic              fin;
  logic [STAT_W-1:0] stat, stat_next;
  logic              hold_valid, hold_valid_next;
  logic [CHAR_W-1:0] hold, hold_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CODE_W-1:0] top;
  logic [CW-1:0]     count_dec;

  logic accept, full, out_free;
  logic in_close, in_open, in_op;
  logic top_is_op, pop_it, emit_it, chk_stall, need_out;
  logic load_emit, load_done;
  logic [CW-1:0] close_after;
  logic [STAT_W-1:0] acc_stat;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full = (count == FULL_CNT);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign in_close = is_close_char(s_axis_tdata);
  assign in_open  = is_open_char(s_axis_tdata);
  assign in_op    = is_op_char(s_axis_tdata);

  // top of stack always read at count-1; valid in the cycle after count settles
  assign count_dec = count - ONE_CNT;
  assign ram_raddr = count_dec[AW-1:0];

  ifp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (top)
  );

  assign top_is_op = (top < CODE_CLOSE_BASE);
  always_comb begin
    case (mode)
      MODE_FLUSH: pop_it = 1'b1;
      MODE_OPEN:  pop_it = top_is_op;
      MODE_OP:    pop_it = (code_prec(top) > code_prec(op_code));
      default:    pop_it = 1'b0;
    endcase
  end
  assign emit_it   = pop_it && top_is_op;
  assign chk_stall = emit_it && hold_valid && !out_free;
  assign need_out  = hold_valid || (stat != STAT_OK) || fin;
  assign load_emit = (state == ST_CHK) && emit_it && hold_valid && !chk_stall;
  assign load_done = (state == ST_DONE) && need_out && out_free;

  // closing brackets left after this item's own work decide the flush status
  always_comb begin
    close_after = close_cnt;
    if (in_close && !full) begin
      close_after = close_cnt + ONE_CNT;
    end else if (in_open && (close_cnt != '0)) begin
      close_after = close_cnt - ONE_CNT;
    end
    if (in_close && full) begin
      acc_stat = STAT_OVERFLOW;
    end else if (in_open && (close_cnt == '0)) begin
      acc_stat = STAT_UNMATCHED;
    end else if (s_axis_tlast && (close_after != '0)) begin
      acc_stat = STAT_UNMATCHED;
    end else begin
      acc_stat = STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_open || in_op) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_AFTER;
          end
        end
      end
      ST_RD: begin
        if (count != '0) begin
          state_next = ST_CHK;
        end else if (mode == MODE_OP) begin
          state_next = ST_PUSH;
        end else if (mode == MODE_FLUSH) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_AFTER;
        end
      end
      ST_CHK: begin
        if (chk_stall) begin
          state_next = ST_CHK;
        end else if (pop_it) begin
          state_next = ST_RD;
        end else if (mode == MODE_OP) begin
          state_next = ST_PUSH;
        end else begin
          state_next = ST_AFTER;
        end
      end
      ST_PUSH:  state_next = ST_AFTER;
      ST_AFTER: state_next = fin ? ST_RD : ST_DONE;
      ST_DONE: begin
        if (!need_out || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and stack control
  always_comb begin
    mode_next       = mode;
    count_next      = count;
    close_cnt_next  = close_cnt;
    stat_next       = stat;
    hold_valid_next = hold_valid;
    hold_next       = hold;
    ram_we          = 1'b0;
    ram_waddr       = count[AW-1:0];
    ram_wdata       = op_code;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          stat_next = acc_stat;
          if (in_close) begin
            ram_wdata = char_code(s_axis_tdata);
            if (!full) begin
              ram_we         = 1'b1;
              count_next     = count + ONE_CNT;
              close_cnt_next = close_cnt + ONE_CNT;
            end
          end else if (in_open) begin
            mode_next = MODE_OPEN;
          end else if (in_op) begin
            mode_next = MODE_OP;
          end else begin
            hold_valid_next = 1'b1;
            hold_next       = s_axis_tdata;
          end
        end
      end
      ST_CHK: begin
        if (!chk_stall) begin
          if (pop_it) begin
            count_next = count_dec;
            if (emit_it) begin
              hold_valid_next = 1'b1;
              hold_next       = code_char(top);
            end
          end else if (mode == MODE_OPEN) begin
            // matching closing bracket is dropped
            count_next     = count_dec;
            close_cnt_next = close_cnt - ONE_CNT;
          end
        end
      end
      ST_PUSH: begin
        if (full) begin
          stat_next = STAT_OVERFLOW;
        end else begin
          ram_we     = 1'b1;
          count_next = count + ONE_CNT;
        end
      end
      ST_AFTER: begin
        if (fin) begin
          mode_next = MODE_FLUSH;
        end
      end
      ST_DONE: begin
        if (load_done) begin
          hold_valid_next = 1'b0;
        end
        if (fin) begin
          count_next     = '0;
          close_cnt_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= MODE_OPEN;
      count         <= '0;
      close_cnt     <= '0;
      hold_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      count      <= count_next;
      close_cnt  <= close_cnt_next;
      hold_valid <= hold_valid_next;
      if (load_emit || load_done) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stat <= stat_next;
    hold <= hold_next;
    if (accept) begin
      fin     <= s_axis_tlast;
      op_code <= char_code(s_axis_tdata);
    end
    if (load_emit) begin
      m_axis_tdata <= hold;
      m_axis_tlast <= 1'b0;
      m_axis_tuser <= {stat, 1'b0};
    end else if (load_done) begin
      m_axis_tdata <= hold_valid ? hold : '0;
      m_axis_tlast <= 1'b1;
      m_axis_tuser <= {stat, fin};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("stack count beyond depth");

  a_close_le_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (close_cnt <= count))
    else $error("more closing brackets than stack entries");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("pending character left behind at item end");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && fin && state_next == ST_IDLE) |=> (count == '0))
    else $error("stack not empty after final item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_emit || load_done) |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

### sim/tb_infix_to_prefix_operator_stack_core.sv
// Self-checking testbench for infix_to_prefix_operator_stack_core: drives
// expressions right to left and checks each output char against a predictor.
// Depends on ifp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_infix_to_prefix_operator_stack_core
  import ifp_pkg::*;
();

  localparam int        DEPTH      = DEF_STACK_DEPTH;
  localparam int        DRAIN_MAX  = 20000;
  localparam realtime   RUN_LIMIT  = 20_000_000;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_FILLER = 8'h00;

  typedef struct packed {
    logic [7:0]        ch;
    logic              run_last;
    logic              expr_done;
    logic [STAT_W-1:0] status;
  } prefix_out_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic [2:0]        m_axis_tuser;

  // predictor state: operator / closing bracket stack
  logic [CODE_W-1:0] held_ops [DEPTH];
  int                held_count = 0;
  prefix_out_t       expected_chars [$];
  logic [7:0]        expr_text [$];

  int  mismatch_count = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  expr_count = 0;
  int  hold_cycles = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  infix_to_prefix_operator_stack_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d chars sent, %0d pending", sent_count, expected_chars.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] glyph_of(input logic [CODE_W-1:0] code);
    case (code)
      CODE_PLUS:        return CH_PLUS;
      CODE_MINUS:       return CH_MINUS;
      CODE_MUL:         return CH_STAR;
      CODE_DIV:         return CH_SLASH;
      CODE_CLOSE_BRACE: return CH_RBRACE;
      CODE_CLOSE_PAREN: return CH_RPAREN;
      default:          return CH_RBRACK;
    endcase
  endfunction

  function automatic logic [1:0] rank_of(input logic [CODE_W-1:0] code);
    if (code == CODE_PLUS || code == CODE_MINUS) return PREC_ADD;
    if (code == CODE_MUL || code == CODE_DIV) return PREC_MUL;
    return PREC_BRACKET;
  endfunction

  function automatic bit push_op(input logic [CODE_W-1:0] code);
    if (held_count >= DEPTH) return 1'b0;
    held_ops[held_count] = code;
    held_count++;
    return 1'b1;
  endfunction

  // works out the output chars that one accepted input char causes
  function automatic void convert_char(input logic [7:0] ch, input logic fin);
    logic [7:0]        emitted [$];
    logic [STAT_W-1:0] st;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] top;
    bit                is_close;
    bit                is_open;
    bit                is_op;
    int                k;
    st = STAT_OK;
    is_close = 1'b0;
    is_open = 1'b0;
    is_op = 1'b0;
    code = CODE_PLUS;
    case (ch)
      CH_PLUS:   begin code = CODE_PLUS;        is_op = 1'b1; end
      CH_MINUS:  begin code = CODE_MINUS;       is_op = 1'b1; end
      CH_STAR:   begin code = CODE_MUL;         is_op = 1'b1; end
      CH_SLASH:  begin code = CODE_DIV;         is_op = 1'b1; end
      CH_RBRACE: begin code = CODE_CLOSE_BRACE; is_close = 1'b1; end
      CH_RPAREN: begin code = CODE_CLOSE_PAREN; is_close = 1'b1; end
      CH_RBRACK: begin code = CODE_CLOSE_BRACK; is_close = 1'b1; end
      CH_LBRACE, CH_LPAREN, CH_LBRACK: is_open = 1'b1;
      default: ;
    endcase

    if (is_close) begin
      if (!push_op(code) && st == STAT_OK) st = STAT_OVERFLOW;
    end else if (is_open) begin
      while (held_count > 0 && held_ops[held_count-1] < CODE_CLOSE_BASE) begin
        emitted.push_back(glyph_of(held_ops[held_count-1]));
        held_count--;
      end
      if (held_count > 0) held_count--;
      else if (st == STAT_OK) st = STAT_UNMATCHED;
    end else if (is_op) begin
      while (held_count > 0 && rank_of(held_ops[held_count-1]) > rank_of(code)) begin
        emitted.push_back(glyph_of(held_ops[held_count-1]));
        held_count--;
      end
      if (!push_op(code) && st == STAT_OK) st = STAT_OVERFLOW;
    end else begin
      emitted.push_back(ch);
    end

    // last char flushes: operators come out, leftover closing brackets are dropped
    if (fin) begin
      while (held_count > 0) begin
        top = held_ops[held_count-1];
        held_count--;
        if (top < CODE_CLOSE_BASE) emitted.push_back(glyph_of(top));
        else if (st == STAT_OK) st = STAT_UNMATCHED;
      end
    end

    if (emitted.size() == 0) begin
      if (st == STAT_OK && !fin) return;
      emitted.push_back(CH_FILLER);
    end
    for (k = 0; k < emitted.size(); k++) begin
      expected_chars.push_back('{emitted[k], k == emitted.size() - 1,
                                 (k == emitted.size() - 1) && fin, st});
    end
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : rx_side
    prefix_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checked_count++;
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char %h last %b user %b",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want.ch || m_axis_tlast !== want.run_last ||
            m_axis_tuser[0] !== want.expr_done || m_axis_tuser[2:1] !== want.status) begin
          note_mismatch($sformatf(
            "exp char %h last %b done %b st %0d, got char %h last %b done %b st %0d",
            want.ch, want.run_last, want.expr_done, want.status,
            m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[2:1]));
        end
      end
    end
    // ready for the next cycle: long hold-off, random bursts, or open
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    if (!steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    convert_char(ch, fin);
    sent_count++;
  endtask

  // feeds expr_text right to left, leftmost char flagged as last
  task automatic send_expr();
    int i;
    for (i = expr_text.size() - 1; i >= 0; i--) send_char(expr_text[i], i == 0);
    expr_count++;
  endtask

  task automatic load_text(input string s);
    int i;
    expr_text.delete();
    for (i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
  endtask

  task automatic wait_results_drained();
    int n;
    prefix_out_t lost;
    s_axis_tvalid <= 1'b0;
    for (n = 0; n < DRAIN_MAX && expected_chars.size() != 0; n++) @(posedge clk);
    while (expected_chars.size() != 0) begin
      lost = expected_chars.pop_front();
      note_mismatch($sformatf("exp char %h last %b done %b st %0d, got nothing",
                              lost.ch, lost.run_last, lost.expr_done, lost.status));
    end
  endtask

  function automatic logic [7:0] syntax_glyph(input int k);
    case (k)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_LPAREN;
      5:       return CH_LBRACK;
      6:       return CH_LBRACE;
      7:       return CH_RPAREN;
      8:       return CH_RBRACK;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic bit is_syntax_char(input logic [7:0] ch);
    int k;
    for (k = 0; k < 10; k++) if (ch == syntax_glyph(k)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (is_syntax_char(ch)) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  // random well-formed infix text, bracket kinds mixed freely
  task automatic build_expr(input int n_terms, input int max_nest);
    int nest;
    int t;
    nest = 0;
    expr_text.delete();
    for (t = 0; t < n_terms; t++) begin
      while (nest < max_nest && $urandom_range(0, 3) == 0) begin
        expr_text.push_back(syntax_glyph($urandom_range(4, 6)));
        nest++;
      end
      repeat ($urandom_range(1, 2)) expr_text.push_back(pick_operand());
      if (nest > 0 && $urandom_range(0, 2) == 0) begin
        expr_text.push_back(syntax_glyph($urandom_range(7, 9)));
        nest--;
      end
      if (t + 1 < n_terms) expr_text.push_back(syntax_glyph($urandom_range(0, 3)));
    end
    while (nest > 0) begin
      expr_text.push_back(syntax_glyph($urandom_range(7, 9)));
      nest--;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    load_text("a+b*c");              // + pops the higher-precedence *
    send_expr();
    send_char(8'h00, 1'b0);          // byte extremes pass straight through
    send_char(8'hFF, 1'b1);
    load_text("[p-q]/(r)");
    send_expr();
    load_text("{a}");
    send_expr();
    send_char(CH_LPAREN, 1'b0);      // opening bracket on empty stack
    send_char(CH_RBRACE, 1'b0);      // push only, no output
    send_char("x", 1'b1);            // flush drops the unmatched closing bracket
    send_char(CH_RBRACE, 1'b1);      // only a zero filler char is emitted on this last char
    send_char(CH_STAR, 1'b1);        // operator pushed then flushed
  endtask

  task automatic test_overflow();
    repeat (DEPTH + 1) send_char(CH_MINUS, 1'b0);
    send_char("w", 1'b1);            // one operand plus a full stack of operators
    repeat (DEPTH + 1) send_char(CH_RPAREN, 1'b0);
    send_char(CH_STAR, 1'b0);
    send_char("z", 1'b1);
  endtask

  // receiver holds off while the sender keeps offering, so the core backs up
  task automatic test_backpressure();
    hold_cycles = 300;
    build_expr(14, 2);
    send_expr();
  endtask

  task automatic test_drain_pause();
    build_expr(5, 2);
    send_expr();
    wait_results_drained();
    build_expr(6, 3);
    send_expr();
  endtask

  task automatic test_random(input int target);
    int i;
    int n;
    while (sent_count < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 80) begin
        build_expr($urandom_range(1, 6), $urandom_range(0, 3));
        // broken text: drop one char somewhere
        if ($urandom_range(0, 9) == 0 && expr_text.size() > 1)
          expr_text.delete($urandom_range(0, expr_text.size() - 1));
        send_expr();
      end else begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          send_char($urandom_range(0, 1) ? syntax_glyph($urandom_range(0, 9))
                                         : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 5) == 0);
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_steady(input int target);
    steady = 1'b1;
    while (sent_count < target) begin
      build_expr($urandom_range(2, 6), 2);
      send_expr();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    test_drain_pause();
    test_random(400);
    test_steady(460);
    wait_results_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d chars in %0d expressions, %0d output chars checked",
             sent_count, expr_count, checked_count);
    $display("incl. stack overflow, unmatched brackets, long receiver hold-off");
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
